@@ hw/rtl/dtsbp_pkg.sv @@
// Shared types, constants and the sample rate table of the DTS burst packer.
package dtsbp_pkg;

    // Largest burst in bytes; longer bursts are capped to this
    localparam int MAX_BURST_BYTES = 6144;

    // Sync word that opens every DTS frame
    localparam logic [31:0] SYNC_WORD = 32'h7FFE8001;

    // Burst preamble and sync words
    localparam logic [15:0] PRE_PA  = 16'hF872;
    localparam logic [15:0] PRE_PB  = 16'h4E1F;
    localparam logic [15:0] SYNC_HI = 16'h7FFE;
    localparam logic [15:0] SYNC_LO = 16'h8001;

    // Frame byte positions
    localparam logic [13:0] HDR_START_POS = 14'd4;
    localparam logic [13:0] HDR_LAST_POS  = 14'd9;
    localparam logic [13:0] PAYLOAD_POS   = 14'd10;

    // Shortest legal frame, sync included
    localparam logic [14:0] MIN_FRAME = 15'd10;

    // Burst data type codes
    localparam logic [3:0] TYPE_OTHER = 4'h0;
    localparam logic [3:0] TYPE_1K    = 4'hA;
    localparam logic [3:0] TYPE_2K    = 4'hB;
    localparam logic [3:0] TYPE_4K    = 4'hC;
    localparam logic [3:0] TYPE_8K    = 4'hD;

    // Block counts with fixed burst sizes
    localparam logic [6:0] NBS_1K = 7'd7;
    localparam logic [6:0] NBS_2K = 7'd15;
    localparam logic [6:0] NBS_4K = 7'd31;
    localparam logic [6:0] NBS_8K = 7'd63;
    localparam logic [6:0] NBS_MIN = 7'd5;
    localparam logic [6:0] NBS_MAX = 7'd127;

    localparam logic [14:0] BURST_1K  = 15'd1024;
    localparam logic [14:0] BURST_2K  = 15'd2048;
    localparam logic [14:0] BURST_4K  = 15'd4096;
    localparam logic [14:0] BURST_8K  = 15'd8192;
    localparam logic [14:0] BURST_CAP = 15'(MAX_BURST_BYTES);

    // Preamble word slots, in send order
    localparam logic [3:0] SLOT_PA   = 4'd0;
    localparam logic [3:0] SLOT_PB   = 4'd1;
    localparam logic [3:0] SLOT_PC   = 4'd2;
    localparam logic [3:0] SLOT_PD   = 4'd3;
    localparam logic [3:0] SLOT_SYH  = 4'd4;
    localparam logic [3:0] SLOT_SYL  = 4'd5;
    localparam logic [3:0] SLOT_HDR0 = 4'd6;
    localparam logic [3:0] SLOT_HDR1 = 4'd7;
    localparam logic [3:0] SLOT_HDR2 = 4'd8;

    // Config reset value
    localparam logic [15:0] RATE_RESET = 16'd48000;

    // Queue geometry (depth is a power of two)
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    // One queued job: a whole preamble or a single payload word
    typedef struct packed {
        logic        is_pre;
        logic [3:0]  tc;
        logic [47:0] hdr;
        logic [15:0] word;
        logic        last;
        logic [12:0] pad;
    } dtsbp_entry_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } dtsbp_qstat_t;

    // Sample rate code to Hz; unused codes give zero
    function automatic logic [15:0] rate_lookup(input logic [3:0] code);
        logic [15:0] hz;
        case (code)
            4'd1, 4'd2, 4'd3:    hz = 16'd32000;
            4'd6, 4'd7, 4'd8:    hz = 16'd44100;
            4'd11, 4'd12, 4'd13: hz = 16'd48000;
            default:             hz = 16'd0;
        endcase
        return hz;
    endfunction

endpackage

@@ hw/rtl/dts_iec61937_burst_packer_top.sv @@
// Top level of the DTS to IEC 61937 burst packer.
//
// Takes one stream byte per beat, hunts for the DTS sync word, checks the
// six header bytes that follow and, for a good frame, sends the burst
// preamble (Pa, Pb, Pc, Pd), the sync words, the header and the payload as
// big-endian 16-bit words; the final word has last set and pad_bytes gives
// the zero bytes that fill the burst. Rejected headers (burst shorter than
// frame, frame under 10 bytes, rate not equal to expected_rate) produce no
// output and hunting resumes. Input is taken at one byte per cycle whenever
// the four-entry job queue has room. The byte that completes a word or a
// good header becomes a queue entry on its own beat, and the word sequencer
// then reads it from the queue into its registered output stage. A good
// header expands into nine preamble words in the word sequencer while
// payload words arrive one per two input bytes, so for frames of 16 bytes
// or more the queue fills during the preamble and input stalls; after that,
// steady input runs at one byte per cycle except when the output side stalls.
// expected_rate is written over the cfg channel, which is always ready; the
// user must write it only while the block is idle; the block does not enforce it.
module dts_iec61937_burst_packer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] word,
    output logic        last,
    output logic [12:0] pad_bytes,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic [15:0]             expected_rate_reg;
    logic                    push;
    logic                    pop;
    dtsbp_pkg::dtsbp_entry_t push_data;
    dtsbp_pkg::dtsbp_entry_t head;
    dtsbp_pkg::dtsbp_qstat_t qstat;

    // Rate register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_rate_reg <= dtsbp_pkg::RATE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            expected_rate_reg <= cfg_data;
        end
    end

    dtsbp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .expected_rate (expected_rate_reg),
        .qstat         (qstat),
        .push          (push),
        .push_data     (push_data)
    );

    dtsbp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (head),
        .qstat     (qstat)
    );

    dtsbp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .qstat     (qstat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .word      (word),
        .last      (last),
        .pad_bytes (pad_bytes)
    );

    // Pad count only rides on the final word of a burst
    a_pad_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> pad_bytes == 13'd0)
        else $error("pad_bytes nonzero on a word that is not last");

    // Front never writes a full queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("job pushed into full queue");

    // Back never drains an empty queue
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("job popped from empty queue");

endmodule

@@ hw/rtl/dtsbp_front.sv @@
// Front end: sync hunt, header decode and check, payload byte pairing.
module dtsbp_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [7:0]              data_byte,
    input  logic [15:0]             expected_rate,
    input  dtsbp_pkg::dtsbp_qstat_t qstat,
    output logic                    push,
    output dtsbp_pkg::dtsbp_entry_t push_data
);

    logic [31:0] sync_shift_reg, sync_shift_next;
    logic [13:0] pos_reg, pos_next;
    logic [7:0]  hdr_reg [0:4];
    logic [7:0]  held_reg, held_next;
    logic [13:0] flen_reg, flen_next;
    logic [12:0] pad_reg, pad_next;

    logic        acc;
    logic        in_frame;
    logic [13:0] pos_inc;
    logic        hdr_we;
    logic [2:0]  hdr_idx;

    // decode of the registered header bytes
    logic [6:0]  nbs;
    logic [6:0]  nbs_eff;
    logic [7:0]  nbs_p1;
    logic [3:0]  tc;
    logic [14:0] burst_raw;
    logic [14:0] burst;
    logic [14:0] fl;
    logic [14:0] fl_even;
    logic [15:0] used;
    logic [15:0] burst16;
    logic [12:0] pad;
    logic [15:0] rate;
    logic        hdr_ok;

    // Header decode
    always_comb
    begin
        nbs     = {hdr_reg[0][0], hdr_reg[1][7:2]};
        nbs_eff = (nbs < dtsbp_pkg::NBS_MIN) ? dtsbp_pkg::NBS_MAX : nbs;
        nbs_p1  = {1'b0, nbs_eff} + 8'd1;
        case (nbs)
            dtsbp_pkg::NBS_1K:
            begin
                tc = dtsbp_pkg::TYPE_1K;
                burst_raw = dtsbp_pkg::BURST_1K;
            end
            dtsbp_pkg::NBS_2K:
            begin
                tc = dtsbp_pkg::TYPE_2K;
                burst_raw = dtsbp_pkg::BURST_2K;
            end
            dtsbp_pkg::NBS_4K:
            begin
                tc = dtsbp_pkg::TYPE_4K;
                burst_raw = dtsbp_pkg::BURST_4K;
            end
            dtsbp_pkg::NBS_8K:
            begin
                tc = dtsbp_pkg::TYPE_8K;
                burst_raw = dtsbp_pkg::BURST_8K;
            end
            default:
            begin
                tc = dtsbp_pkg::TYPE_OTHER;
                burst_raw = {1'b0, nbs_p1, 6'd0} + 15'd2;
            end
        endcase
        burst = (burst_raw > dtsbp_pkg::BURST_CAP) ? dtsbp_pkg::BURST_CAP : burst_raw;

        fl      = {1'b0, hdr_reg[1][1:0], hdr_reg[2], hdr_reg[3][7:4]} + 15'd1;
        fl_even = fl + {14'd0, fl[0]};
        used    = {1'b0, fl_even} + 16'd8;
        burst16 = {1'b0, burst};
        pad     = (burst16 > used) ? 13'(burst16 - used) : 13'd0;

        rate   = dtsbp_pkg::rate_lookup(hdr_reg[4][5:2]);
        hdr_ok = !(burst < fl) && !(fl < dtsbp_pkg::MIN_FRAME) && (rate == expected_rate);
    end

    // Byte classification and job generation
    always_comb
    begin
        in_ready = !qstat.full;
        acc      = in_valid && in_ready;
        in_frame = (sync_shift_reg == dtsbp_pkg::SYNC_WORD);
        pos_inc  = pos_reg + 14'd1;
        hdr_idx  = 3'(pos_reg - dtsbp_pkg::HDR_START_POS);
        hdr_we   = acc && in_frame && (pos_reg < dtsbp_pkg::HDR_LAST_POS);

        sync_shift_next = sync_shift_reg;
        pos_next        = pos_reg;
        held_next       = held_reg;
        flen_next       = flen_reg;
        pad_next        = pad_reg;
        push            = 1'b0;
        push_data       = '0;

        if (acc)
        begin
            if (!in_frame)
            begin
                sync_shift_next = {sync_shift_reg[23:0], data_byte};
            end
            else if (pos_reg < dtsbp_pkg::PAYLOAD_POS)
            begin
                pos_next = pos_inc;
                if (pos_reg == dtsbp_pkg::HDR_LAST_POS)
                begin
                    if (hdr_ok)
                    begin
                        push             = 1'b1;
                        push_data.is_pre = 1'b1;
                        push_data.tc     = tc;
                        push_data.hdr    = {hdr_reg[0], hdr_reg[1], hdr_reg[2],
                                            hdr_reg[3], hdr_reg[4], data_byte};
                        push_data.word   = {fl[12:0], 3'b000};
                        flen_next        = fl[13:0];
                        pad_next         = pad;
                        if (fl == dtsbp_pkg::MIN_FRAME)
                        begin
                            // frame ends on the last header word
                            push_data.last  = 1'b1;
                            push_data.pad   = pad;
                            sync_shift_next = '1;
                            pos_next        = dtsbp_pkg::HDR_START_POS;
                        end
                    end
                    else
                    begin
                        sync_shift_next = '1;
                        pos_next        = dtsbp_pkg::HDR_START_POS;
                    end
                end
            end
            else if (!pos_reg[0])
            begin
                // high byte of a payload word
                held_next = data_byte;
                pos_next  = pos_inc;
                if (pos_inc >= flen_reg)
                begin
                    push            = 1'b1;
                    push_data.word  = {data_byte, 8'h00};
                    push_data.last  = 1'b1;
                    push_data.pad   = pad_reg;
                    sync_shift_next = '1;
                    pos_next        = dtsbp_pkg::HDR_START_POS;
                end
            end
            else
            begin
                // low byte completes the word
                pos_next       = pos_inc;
                push           = 1'b1;
                push_data.word = {held_reg, data_byte};
                if (pos_inc >= flen_reg)
                begin
                    push_data.last  = 1'b1;
                    push_data.pad   = pad_reg;
                    sync_shift_next = '1;
                    pos_next        = dtsbp_pkg::HDR_START_POS;
                end
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_shift_reg <= '1;
            pos_reg        <= dtsbp_pkg::HDR_START_POS;
        end
        else
        begin
            sync_shift_reg <= sync_shift_next;
            pos_reg        <= pos_next;
        end
    end

    // Header bytes and frame data, always written before use
    always_ff @(posedge clk)
    begin
        if (hdr_we)
        begin
            hdr_reg[hdr_idx] <= data_byte;
        end
        held_reg <= held_next;
        flen_reg <= flen_next;
        pad_reg  <= pad_next;
    end

endmodule

@@ hw/rtl/dtsbp_fifo.sv @@
// Job queue between the front end and the word sequencer.
module dtsbp_fifo (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  dtsbp_pkg::dtsbp_entry_t push_data,
    input  logic                    pop,
    output dtsbp_pkg::dtsbp_entry_t pop_data,
    output dtsbp_pkg::dtsbp_qstat_t qstat
);

    dtsbp_pkg::dtsbp_entry_t mem [0:dtsbp_pkg::QUEUE_DEPTH-1];

    logic [dtsbp_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [dtsbp_pkg::QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [dtsbp_pkg::QUEUE_AW:0]   count_reg, count_next;

    // Pointer and fill update
    always_comb
    begin
        qstat.full  = (count_reg == (dtsbp_pkg::QUEUE_AW+1)'(dtsbp_pkg::QUEUE_DEPTH));
        qstat.empty = (count_reg == '0);
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
        pop_data = mem[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hw/rtl/dtsbp_back.sv @@
// Back end: expands queued jobs into output words behind a registered output stage.
module dtsbp_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  dtsbp_pkg::dtsbp_entry_t head,
    input  dtsbp_pkg::dtsbp_qstat_t qstat,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [15:0]             word,
    output logic                    last,
    output logic [12:0]             pad_bytes
);

    logic [3:0]  slot_reg, slot_next;
    logic        valid_reg, valid_next;
    logic [15:0] word_reg, word_next;
    logic        last_reg, last_next;
    logic [12:0] pad_reg, pad_next;

    logic        can_load;
    logic        gen;
    logic        pre_done;
    logic [15:0] pre_word;

    // Preamble word for the current slot
    always_comb
    begin
        case (slot_reg)
            dtsbp_pkg::SLOT_PA:   pre_word = dtsbp_pkg::PRE_PA;
            dtsbp_pkg::SLOT_PB:   pre_word = dtsbp_pkg::PRE_PB;
            dtsbp_pkg::SLOT_PC:   pre_word = {12'd0, head.tc};
            dtsbp_pkg::SLOT_PD:   pre_word = head.word;
            dtsbp_pkg::SLOT_SYH:  pre_word = dtsbp_pkg::SYNC_HI;
            dtsbp_pkg::SLOT_SYL:  pre_word = dtsbp_pkg::SYNC_LO;
            dtsbp_pkg::SLOT_HDR0: pre_word = head.hdr[47:32];
            dtsbp_pkg::SLOT_HDR1: pre_word = head.hdr[31:16];
            dtsbp_pkg::SLOT_HDR2: pre_word = head.hdr[15:0];
            default:              pre_word = '0;
        endcase
    end

    // Sequencing and output stage load
    always_comb
    begin
        can_load   = !valid_reg || out_ready;
        gen        = !qstat.empty && can_load;
        pre_done   = (slot_reg == dtsbp_pkg::SLOT_HDR2);
        pop        = gen && (!head.is_pre || pre_done);

        slot_next  = slot_reg;
        valid_next = valid_reg && !out_ready;
        word_next  = word_reg;
        last_next  = last_reg;
        pad_next   = pad_reg;

        if (gen)
        begin
            valid_next = 1'b1;
            if (head.is_pre)
            begin
                word_next = pre_word;
                last_next = pre_done && head.last;
                pad_next  = pre_done ? head.pad : 13'd0;
                slot_next = pre_done ? dtsbp_pkg::SLOT_PA : slot_reg + 4'd1;
            end
            else
            begin
                word_next = head.word;
                last_next = head.last;
                pad_next  = head.pad;
            end
        end

        out_valid = valid_reg;
        word      = word_reg;
        last      = last_reg;
        pad_bytes = pad_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= dtsbp_pkg::SLOT_PA;
            valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg  <= slot_next;
            valid_reg <= valid_next;
        end
    end

    // Output beat payload
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        last_reg <= last_next;
        pad_reg  <= pad_next;
    end

endmodule
